>>> hw/rtl/dti_pkg.sv
`timescale 1ns / 1ps

package dti_pkg;

  localparam int MaxDepth    = 8;
  localparam int NumFeatures = 64;
  localparam int NumClasses  = 16;

  localparam int NodeAw      = 8;
  localparam int FeatAw      = 6;
  localparam int DepthW      = $clog2(MaxDepth + 1);
  localparam int QueueDepth  = 2;
  localparam int QueueAw     = $clog2(QueueDepth);

  localparam logic [1:0] OpWriteNode = 2'd0;
  localparam logic [1:0] OpWriteFeat = 2'd1;
  localparam logic [1:0] OpClassify  = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         node_index;
    logic               is_split;
    logic [5:0]         split_feature;
    logic signed [15:0] threshold;
    logic [3:0]         leaf_class;
    logic [5:0]         feature_index;
    logic signed [15:0] feature_value;
  } in_req_t;

  typedef struct packed {
    logic [3:0] predicted_class;
    logic [7:0] leaf_node;
  } out_rsp_t;

  typedef struct packed {
    logic               is_split;
    logic [5:0]         split_feature;
    logic signed [15:0] threshold;
    logic [3:0]         leaf_class;
  } node_t;

  typedef enum logic [1:0] {
    CmdNode,
    CmdFeat,
    CmdClassify
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [NodeAw-1:0]  node_index;
    node_t              node;
    logic [FeatAw-1:0]  feature_index;
    logic signed [15:0] feature_value;
  } cmd_t;

endpackage

>>> hw/rtl/decision_tree_inference.sv
// decision tree classifier over a heap-ordered node store (root is node 1)
// input channel in_valid_i / in_ready_o / in_req_i carries one request:
//   write node, write feature element, or classify the loaded vector
// output channel out_valid_o / out_ready_i / out_rsp_o returns the leaf class
//   and leaf index, one response per classify request, none for writes
// a front end decodes requests into a two-entry queue; a back end with the
//   node and feature memories executes them in order
// write requests are done as the back end takes them from the queue
// classify: a node read for each level, then for each split level a feature
//   read and compare; the request is taken first, and the walk ends in a done
//   state that loads the response register; the walk also ends at the depth
//   limit or when a child index runs past the node store
// one classify is in the back end at a time; writes behind it wait in the queue
// the response sits in an output register; while the receiver stalls, the
//   back end keeps taking writes and walks the next classify, holding it at
//   the end until the register frees
// reset empties the queue and output register; node and feature memories
//   are not cleared and must be written before they are used
`timescale 1ns / 1ps

module decision_tree_inference (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dti_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dti_pkg::out_rsp_t out_rsp_o
);

  logic          fr_valid, fr_ready;
  dti_pkg::cmd_t fr_cmd;
  logic          bk_valid, bk_ready;
  dti_pkg::cmd_t bk_cmd;

  dti_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  dti_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_cmd_i   (fr_cmd),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_cmd_o    (bk_cmd)
  );

  dti_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (bk_valid),
    .cmd_ready_o (bk_ready),
    .cmd_i       (bk_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

>>> hw/rtl/dti_front.sv
`timescale 1ns / 1ps

module dti_front (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dti_pkg::in_req_t in_req_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output dti_pkg::cmd_t    cmd_o
);

  logic keep;

  // unknown operations and out-of-range feature writes are dropped here
  always_comb begin
    keep                      = 1'b0;
    cmd_o.kind                = dti_pkg::CmdClassify;
    cmd_o.node_index          = in_req_i.node_index;
    cmd_o.node.is_split       = in_req_i.is_split;
    cmd_o.node.split_feature  = in_req_i.split_feature;
    cmd_o.node.threshold      = in_req_i.threshold;
    cmd_o.node.leaf_class     = in_req_i.leaf_class;
    cmd_o.feature_index       = in_req_i.feature_index[dti_pkg::FeatAw-1:0];
    cmd_o.feature_value       = in_req_i.feature_value;
    unique case (in_req_i.operation)
      dti_pkg::OpWriteNode: begin
        keep       = 1'b1;
        cmd_o.kind = dti_pkg::CmdNode;
      end
      dti_pkg::OpWriteFeat: begin
        keep       = ({1'b0, in_req_i.feature_index} < 7'(dti_pkg::NumFeatures));
        cmd_o.kind = dti_pkg::CmdFeat;
      end
      dti_pkg::OpClassify: begin
        keep       = 1'b1;
        cmd_o.kind = dti_pkg::CmdClassify;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i && keep;

endmodule

>>> hw/rtl/dti_queue.sv
`timescale 1ns / 1ps

module dti_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  dti_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output dti_pkg::cmd_t pop_cmd_o
);

  dti_pkg::cmd_t                 entry_q [dti_pkg::QueueDepth];
  logic [dti_pkg::QueueAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [dti_pkg::QueueAw:0]     count_q;
  logic                          push, pop;

  assign push_ready_o = (count_q != (dti_pkg::QueueAw + 1)'(dti_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/dti_back.sv
`timescale 1ns / 1ps

module dti_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  dti_pkg::cmd_t     cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dti_pkg::out_rsp_t out_rsp_o
);

  typedef enum logic [1:0] {
    StIdle,
    StNode,
    StFeat,
    StDone
  } state_e;

  state_e                        state_q, state_d;
  logic [dti_pkg::NodeAw-1:0]    cur_q, cur_d;
  logic [dti_pkg::DepthW-1:0]    depth_q, depth_d;
  logic                          out_valid_q, out_valid_d;
  dti_pkg::out_rsp_t             out_q, out_d;

  dti_pkg::node_t                node_mem [2**dti_pkg::NodeAw];
  logic signed [15:0]            feat_mem [2**dti_pkg::FeatAw];
  dti_pkg::node_t                node_rd_q;
  logic signed [15:0]            feat_rd_q;

  logic                          pop, node_wr, feat_wr;
  logic                          feat_in_range, go_right, at_limit, out_free;
  logic signed [15:0]            feat_val;
  logic [dti_pkg::NodeAw:0]      child;
  logic [3:0]                    cls;

  assign cmd_ready_o = (state_q == StIdle);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign node_wr     = pop && (cmd_i.kind == dti_pkg::CmdNode);
  assign feat_wr     = pop && (cmd_i.kind == dti_pkg::CmdFeat);

  always_ff @(posedge clk_i) begin
    if (node_wr) begin
      node_mem[cmd_i.node_index] <= cmd_i.node;
    end
    node_rd_q <= node_mem[cur_d];
  end

  always_ff @(posedge clk_i) begin
    if (feat_wr) begin
      feat_mem[cmd_i.feature_index] <= cmd_i.feature_value;
    end
    feat_rd_q <= feat_mem[node_rd_q.split_feature[dti_pkg::FeatAw-1:0]];
  end

  assign feat_in_range = ({1'b0, node_rd_q.split_feature} < 7'(dti_pkg::NumFeatures));
  assign feat_val      = feat_in_range ? feat_rd_q : 16'sd0;
  assign go_right      = (feat_val > node_rd_q.threshold);
  assign child         = {cur_q, go_right};
  assign at_limit      = (depth_q >= dti_pkg::DepthW'(dti_pkg::MaxDepth));
  assign out_free      = !out_valid_q || out_ready_i;
  assign cls           = ({1'b0, node_rd_q.leaf_class} >= 5'(dti_pkg::NumClasses))
                         ? 4'(dti_pkg::NumClasses - 1) : node_rd_q.leaf_class;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    depth_d     = depth_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    unique case (state_q)
      StIdle: begin
        if (pop && (cmd_i.kind == dti_pkg::CmdClassify)) begin
          cur_d   = dti_pkg::NodeAw'(1);
          depth_d = dti_pkg::DepthW'(1);
          state_d = StNode;
        end
      end
      StNode: begin
        if (!node_rd_q.is_split || at_limit) begin
          state_d = StDone;
        end else begin
          state_d = StFeat;
        end
      end
      StFeat: begin
        if (child[dti_pkg::NodeAw]) begin
          state_d = StDone;
        end else begin
          cur_d   = child[dti_pkg::NodeAw-1:0];
          depth_d = depth_q + 1'b1;
          state_d = StNode;
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.predicted_class = cls;
          out_d.leaf_node       = cur_q;
          state_d               = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cur_q       <= '0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

>>> hw/rtl/dti_checker.sv
`timescale 1ns / 1ps

module dti_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input dti_pkg::in_req_t  in_req_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input dti_pkg::out_rsp_t out_rsp_o
);

  // response held while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed while stalled");

  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("response valid during reset");

  // a walk starts at the root and never lands on node 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.leaf_node != 8'd0)
    else $error("leaf index zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(rst_ni, 1) && $past(rst_ni, 2))
    else $error("response too soon after reset");

endmodule

bind decision_tree_inference dti_checker u_dti_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
